// ===== rtl/rcfb_pkg.sv =====
`default_nettype none
package rcfb_pkg;

  localparam int unsigned FrameLen   = 32;
  localparam int unsigned SumLen     = 30;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned InDataW    = 80;
  localparam int unsigned OutDataW   = 16;

  localparam logic [7:0]  HeaderReset = 8'hA5;
  localparam logic [6:0]  SeqWrap     = 7'd99;
  localparam logic [12:0] PitchBase   = 13'd4096;

  // byte positions in the frame
  localparam logic [IdxW-1:0] PosHeader  = 5'd0;
  localparam logic [IdxW-1:0] PosSeq     = 5'd1;
  localparam logic [IdxW-1:0] PosThrLo   = 5'd2;
  localparam logic [IdxW-1:0] PosThrHi   = 5'd3;
  localparam logic [IdxW-1:0] PosYawLo   = 5'd4;
  localparam logic [IdxW-1:0] PosYawHi   = 5'd5;
  localparam logic [IdxW-1:0] PosPitLo   = 5'd6;
  localparam logic [IdxW-1:0] PosPitHi   = 5'd7;
  localparam logic [IdxW-1:0] PosRolLo   = 5'd8;
  localparam logic [IdxW-1:0] PosRolHi   = 5'd9;
  localparam logic [IdxW-1:0] PosKey     = 5'd10;
  localparam logic [IdxW-1:0] PosGainP   = 5'd20;
  localparam logic [IdxW-1:0] PosGainD   = 5'd21;
  localparam logic [IdxW-1:0] PosSumLo   = 5'd30;
  localparam logic [IdxW-1:0] PosSumHi   = 5'd31;
  localparam logic [IdxW-1:0] PosLast    = 5'd31;

  localparam logic [1:0] KeyNone = 2'd0;
  localparam logic [1:0] KeyOne  = 2'd1;
  localparam logic [1:0] KeyTwo  = 2'd2;

  typedef struct packed {
    logic [7:0]  header;
    logic [6:0]  seq;
    logic [9:0]  thr;
    logic [9:0]  yaw;
    logic [10:0] pit;
    logic [9:0]  rol;
    logic [1:0]  key;
    logic [7:0]  gain_p;
    logic [7:0]  gain_d;
  } frame_t;

endpackage
`default_nettype wire

// ===== rtl/rcfb_pack.sv =====
`default_nettype none
module rcfb_pack (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [rcfb_pkg::InDataW-1:0]     in_tdata,
  input  wire  [7:0]                       header,
  output logic                             pk_valid,
  input  wire                              pk_take,
  output rcfb_pkg::frame_t                 pk_frame
);

  logic              valid_r, valid_nxt;
  logic [6:0]        seq_r, seq_nxt;
  rcfb_pkg::frame_t  frame_r, frame_nxt;
  logic [6:0]        seq_inc;
  logic [12:0]       pit_inv;
  logic              acc;

  assign in_tready = !valid_r || pk_take;
  assign acc       = in_tvalid && in_tready;
  assign seq_inc   = seq_r + 7'd1;
  assign pit_inv   = rcfb_pkg::PitchBase - {1'b0, in_tdata[35:24]};

  always_comb begin
    frame_nxt        = frame_r;
    frame_nxt.header = header;
    frame_nxt.seq    = seq_inc;
    frame_nxt.thr    = in_tdata[11:2];
    frame_nxt.yaw    = in_tdata[23:14];
    frame_nxt.pit    = pit_inv[12:2];
    frame_nxt.rol    = in_tdata[47:38];
    if (in_tdata[48]) begin
      frame_nxt.key = rcfb_pkg::KeyOne;
    end else if (in_tdata[49]) begin
      frame_nxt.key = rcfb_pkg::KeyTwo;
    end else begin
      frame_nxt.key = rcfb_pkg::KeyNone;
    end
    frame_nxt.gain_p = in_tdata[61:54];
    frame_nxt.gain_d = in_tdata[73:66];
  end

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    if (acc) begin
      valid_nxt = 1'b1;
      seq_nxt   = (seq_inc >= rcfb_pkg::SeqWrap) ? 7'd0 : seq_inc;
    end else if (pk_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seq_r   <= 7'd0;
    end else begin
      valid_r <= valid_nxt;
      seq_r   <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      frame_r <= frame_nxt;
    end
  end

  assign pk_valid = valid_r;
  assign pk_frame = frame_r;

endmodule
`default_nettype wire

// ===== rtl/rcfb_serial.sv =====
`default_nettype none
module rcfb_serial (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              pk_valid,
  output logic                             pk_take,
  input  wire  rcfb_pkg::frame_t           pk_frame,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [rcfb_pkg::OutDataW-1:0]    out_tdata,
  output logic                             out_tlast
);

  logic                          busy_r, busy_nxt;
  logic [rcfb_pkg::IdxW-1:0]     idx_r, idx_nxt;
  logic [15:0]                   sum_r, sum_nxt;
  rcfb_pkg::frame_t              frame_r;
  logic [7:0]                    byte_sel;
  logic                          xfer, last;

  always_comb begin
    case (idx_r)
      rcfb_pkg::PosHeader: byte_sel = frame_r.header;
      rcfb_pkg::PosSeq:    byte_sel = {1'b0, frame_r.seq};
      rcfb_pkg::PosThrLo:  byte_sel = frame_r.thr[7:0];
      rcfb_pkg::PosThrHi:  byte_sel = {6'd0, frame_r.thr[9:8]};
      rcfb_pkg::PosYawLo:  byte_sel = frame_r.yaw[7:0];
      rcfb_pkg::PosYawHi:  byte_sel = {6'd0, frame_r.yaw[9:8]};
      rcfb_pkg::PosPitLo:  byte_sel = frame_r.pit[7:0];
      rcfb_pkg::PosPitHi:  byte_sel = {5'd0, frame_r.pit[10:8]};
      rcfb_pkg::PosRolLo:  byte_sel = frame_r.rol[7:0];
      rcfb_pkg::PosRolHi:  byte_sel = {6'd0, frame_r.rol[9:8]};
      rcfb_pkg::PosKey:    byte_sel = {6'd0, frame_r.key};
      rcfb_pkg::PosGainP:  byte_sel = frame_r.gain_p;
      rcfb_pkg::PosGainD:  byte_sel = frame_r.gain_d;
      rcfb_pkg::PosSumLo:  byte_sel = sum_r[7:0];
      rcfb_pkg::PosSumHi:  byte_sel = sum_r[15:8];
      default:             byte_sel = 8'd0;
    endcase
  end

  assign last    = (idx_r == rcfb_pkg::PosLast);
  assign xfer    = busy_r && out_tready;
  assign pk_take = pk_valid && (!busy_r || (xfer && last));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    sum_nxt  = sum_r;
    if (pk_take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      sum_nxt  = 16'd0;
    end else if (xfer) begin
      if (last) begin
        busy_nxt = 1'b0;
      end
      idx_nxt = idx_r + 5'd1;
      // running checksum over the summed part of the frame
      if (idx_r < rcfb_pkg::PosSumLo) begin
        sum_nxt = sum_r + {8'd0, byte_sel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (pk_take) begin
      frame_r <= pk_frame;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {3'd0, idx_r, byte_sel};
  assign out_tlast  = last;

endmodule
`default_nettype wire

// ===== rtl/remote_control_frame_builder.sv =====
`default_nettype none
// channel | direction | transfer carries
// in_     | slave     | one set of stick, key and gain samples
// out_    | master    | one frame byte, its position, tlast on byte 31
// cfg_    | slave     | header byte, always ready
//
// Each sample set gives 32 bytes at one byte per cycle while out_tready is high;
// the byte counter of the serialiser steps through them in order.
// The next sample set is taken while the current frame is still going out.
// Stalls on out_tready hold the byte; the checksum is summed as bytes leave.
// rst_n is synchronous: header returns to 0xA5, sequence count to zero.
module remote_control_frame_builder (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [11:0] throttle_raw, [23:12] yaw_raw, [35:24] pitch_raw, [47:36] roll_raw,
  // [48] key_one, [49] key_two, [61:50] gain_p_raw, [73:62] gain_d_raw
  input  wire  [rcfb_pkg::InDataW-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [7:0] frame_byte, [12:8] byte_index
  output logic [rcfb_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tlast,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [7:0]                      cfg_data
);

  logic [7:0]        header_r, header_nxt;
  logic              pk_valid, pk_take;
  rcfb_pkg::frame_t  pk_frame;

  assign cfg_ready  = 1'b1;
  assign header_nxt = (cfg_valid && cfg_ready) ? cfg_data : header_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= rcfb_pkg::HeaderReset;
    end else begin
      header_r <= header_nxt;
    end
  end

  rcfb_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .header    (header_r),
    .pk_valid  (pk_valid),
    .pk_take   (pk_take),
    .pk_frame  (pk_frame)
  );

  rcfb_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .pk_valid   (pk_valid),
    .pk_take    (pk_take),
    .pk_frame   (pk_frame),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/rcfb_frame_checker.sv =====
module rcfb_frame_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  input  wire                           in_tready,
  input  wire  [rcfb_pkg::InDataW-1:0]  in_tdata,
  input  wire                           out_tvalid,
  input  wire                           out_tready,
  input  wire  [rcfb_pkg::OutDataW-1:0] out_tdata,
  input  wire                           out_tlast,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire  [7:0]                    cfg_data,
  output int                            fails,
  output int                            pending_bytes
);

  typedef struct packed {
    logic [7:0]                value;
    logic [rcfb_pkg::IdxW-1:0] pos;
    logic                      last;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];
  logic [7:0]  header_copy;
  logic [6:0]  seq_copy;

  initial begin
    fails = 0;
    pending_bytes = 0;
    header_copy = rcfb_pkg::HeaderReset;
    seq_copy = '0;
  end

  function automatic void build_frame(input logic [rcfb_pkg::InDataW-1:0] d);
    logic [7:0]  f [rcfb_pkg::FrameLen];
    logic [11:0] thr, yaw, pit, rol, gp, gd;
    logic [12:0] pit_inv;
    logic [15:0] w;
    logic [6:0]  seq;
    logic [15:0] sum;
    frame_byte_t e;
    thr = d[11:0];
    yaw = d[23:12];
    pit = d[35:24];
    rol = d[47:36];
    gp  = d[61:50];
    gd  = d[73:62];
    for (int i = 0; i < rcfb_pkg::FrameLen; i++) f[i] = 8'h00;

    f[rcfb_pkg::PosHeader] = header_copy;
    seq = seq_copy + 7'd1;
    f[rcfb_pkg::PosSeq] = {1'b0, seq};
    seq_copy = (seq >= rcfb_pkg::SeqWrap) ? 7'd0 : seq;

    w = 16'(thr >> 2);
    f[rcfb_pkg::PosThrLo] = w[7:0];
    f[rcfb_pkg::PosThrHi] = w[15:8];
    w = 16'(yaw >> 2);
    f[rcfb_pkg::PosYawLo] = w[7:0];
    f[rcfb_pkg::PosYawHi] = w[15:8];
    pit_inv = rcfb_pkg::PitchBase - {1'b0, pit};
    w = 16'(pit_inv >> 2);
    f[rcfb_pkg::PosPitLo] = w[7:0];
    f[rcfb_pkg::PosPitHi] = w[15:8];
    w = 16'(rol >> 2);
    f[rcfb_pkg::PosRolLo] = w[7:0];
    f[rcfb_pkg::PosRolHi] = w[15:8];

    // key one wins over key two
    if (d[48]) begin
      f[rcfb_pkg::PosKey] = {6'b0, rcfb_pkg::KeyOne};
    end else if (d[49]) begin
      f[rcfb_pkg::PosKey] = {6'b0, rcfb_pkg::KeyTwo};
    end else begin
      f[rcfb_pkg::PosKey] = {6'b0, rcfb_pkg::KeyNone};
    end
    f[rcfb_pkg::PosGainP] = gp[11:4];
    f[rcfb_pkg::PosGainD] = gd[11:4];

    sum = '0;
    for (int i = 0; i < rcfb_pkg::SumLen; i++) sum = sum + {8'h00, f[i]};
    f[rcfb_pkg::PosSumLo] = sum[7:0];
    f[rcfb_pkg::PosSumHi] = sum[15:8];

    for (int i = 0; i < rcfb_pkg::FrameLen; i++) begin
      e.value = f[i];
      e.pos   = i[rcfb_pkg::IdxW-1:0];
      e.last  = (i[rcfb_pkg::IdxW-1:0] == rcfb_pkg::PosLast);
      frame_bytes_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t e;
    if (!rst_n) begin
      header_copy = rcfb_pkg::HeaderReset;
      seq_copy = '0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) header_copy = cfg_data;
      if (in_tvalid && in_tready) build_frame(in_tdata);
      if (out_tvalid && out_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $error("unexpected frame byte transfer: value %0d index %0d last %0d",
                 out_tdata[7:0], out_tdata[12:8], out_tlast);
          fails++;
        end else begin
          e = frame_bytes_q.pop_front();
          if (out_tdata[7:0] !== e.value) begin
            $error("frame_byte mismatch at index %0d: expected %0d, actual %0d",
                   e.pos, e.value, out_tdata[7:0]);
            fails++;
          end
          if (out_tdata[12:8] !== e.pos) begin
            $error("byte_index mismatch: expected %0d, actual %0d",
                   e.pos, out_tdata[12:8]);
            fails++;
          end
          if (out_tlast !== e.last) begin
            $error("last_byte mismatch at index %0d: expected %0d, actual %0d",
                   e.pos, e.last, out_tlast);
            fails++;
          end
        end
      end
    end
    pending_bytes = frame_bytes_q.size();
  end

endmodule

// ===== tb/sv/tb_remote_control_frame_builder.sv =====
module tb_remote_control_frame_builder;

  localparam int StallLimit = 4000;
  localparam int PhaseItems = 136;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [rcfb_pkg::InDataW-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [rcfb_pkg::OutDataW-1:0] out_tdata;
  logic                          out_tlast;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [7:0]                    cfg_data;

  int fails;
  int pending_bytes;
  int in_idle_pct;
  int out_idle_pct;
  int idle_cycles;

  remote_control_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rcfb_frame_checker frame_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fails        (fails),
    .pending_bytes(pending_bytes)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [rcfb_pkg::InDataW-1:0] pack_samples(
    input logic [11:0] thr, yaw, pit, rol,
    input logic        k1, k2,
    input logic [11:0] gp, gd
  );
    return {{(rcfb_pkg::InDataW-74){1'b0}}, gd, gp, k2, k1, rol, pit, yaw, thr};
  endfunction

  // edge values turn up more often than a flat draw would give
  function automatic logic [11:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic send_samples(input logic [rcfb_pkg::InDataW-1:0] d);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int in_pct, input int out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < n; i++) begin
      // hold off mid-phase until the frames in flight have all gone out
      if (i == n / 2) wait_drained();
      send_samples(pack_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick_sample(), pick_sample()));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("** remote_control_frame_builder: FAILED **");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_idle_pct = 32;
    out_idle_pct = 48;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset header; pitch at zero, both keys, gain step edges
    send_samples(pack_samples(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 12'd0, 12'd0));
    send_samples(pack_samples(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1,
                              12'hFFF, 12'hFFF));
    send_samples(pack_samples(12'd0, 12'hFFF, 12'hFFF, 12'd0, 1'b0, 1'b1, 12'd15, 12'd16));
    send_samples(pack_samples(12'hFFF, 12'd0, 12'd1, 12'hFFF, 1'b1, 1'b0,
                              12'd4080, 12'hFFF));
    send_samples(pack_samples(12'd3, 12'd4, 12'd2048, 12'd1023, 1'b0, 1'b1,
                              12'd255, 12'd256));
    send_samples(pack_samples(12'h555, 12'hAAA, 12'h555, 12'hAAA, 1'b1, 1'b0,
                              12'hAAA, 12'h555));
    send_samples(pack_samples(12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b0, 1'b0,
                              12'h555, 12'hAAA));

    write_header(8'h00);
    send_samples(pack_samples(12'd0, 12'd0, 12'hFFF, 12'd0, 1'b0, 1'b0, 12'd0, 12'd0));
    send_samples(pack_samples(12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 1'b0, 1'b0,
                              12'hFFF, 12'hFFF));
    send_samples(pack_samples(12'd1, 12'd2, 12'd3, 12'd5, 1'b1, 1'b1, 12'd17, 12'd31));

    write_header(8'hFF);
    // high checksum with full-scale throttle, yaw, roll and gains
    send_samples(pack_samples(12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 1'b0, 1'b1,
                              12'hFFF, 12'hFFF));
    send_samples(pack_samples(12'd0, 12'd0, 12'd4, 12'd0, 1'b1, 1'b0, 12'd0, 12'd0));

    write_header(8'($urandom_range(0, 255)));
    run_phase(PhaseItems, 32, 48);
    write_header(8'($urandom_range(0, 255)));
    run_phase(PhaseItems, 48, 32);
    write_header(8'hA5);
    run_phase(PhaseItems, 0, 0);

    wait_drained();
    repeat (40) @(negedge clk);
    if (fails == 0 && pending_bytes == 0) begin
      $display("** remote_control_frame_builder: PASSED **");
    end else begin
      if (pending_bytes != 0) $error("frame bytes never sent: %0d", pending_bytes);
      $display("** remote_control_frame_builder: FAILED **");
    end
    $finish;
  end

endmodule
